/* sv/selective_repeat_receive_reorder_defines.svh */
// selective_repeat_receive_reorder_defines.svh
// assertion macros used by the checker file of the receive reorder block
// no dependencies
`ifndef SELECTIVE_REPEAT_RECEIVE_REORDER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_REORDER_DEFINES_SVH

// property checked on rising edges, switched off while reset is high
`define SRRR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on rising edges, reset included
`define SRRR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/srrr_pkg.sv */
// srrr_pkg.sv
// shared constants, codes and controller/datapath types of the receive reorder block
// no dependencies
package srrr_pkg;

  // default built window depth
  localparam int unsigned WINDOW_DEPTH_DEF = 8;

  // field widths
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LEN_W  = 14;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned WS_W   = 4;
  localparam int unsigned CFG_W  = 16;

  // stored slot: descriptor, length, final flag
  localparam int unsigned SLOT_W = WORD_W + LEN_W + 1;

  // length of a piece that is not the last one
  localparam logic [LEN_W-1:0] FULL_PIECE = LEN_W'(12000);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DLV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIN = 2'd2;

  // input action codes
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_FIN  = 1'b1;

  // configuration register indexes
  localparam logic REG_TOTAL_PACKETS = 1'b0;
  localparam logic REG_WINDOW_SIZE   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;  // register the input word
    logic eval;     // ack or fin, store into the window
    logic load;     // emit the slot at the left edge and slide
  } srrr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;      // captured word causes no result
    logic out_last;  // word in the output register ends the run
  } srrr_stat_t;

endpackage

/* sv/srrr_ram.sv */
// srrr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module srrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/srrr_ctrl.sv */
// srrr_ctrl.sv
// sequencing state machine of the receive reorder block
// depends on srrr_pkg
module srrr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output srrr_pkg::srrr_cmd_t   cmd,
  input  srrr_pkg::srrr_stat_t  stat
);
  import srrr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = stat.drop ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) state_next = stat.out_last ? S_IDLE : S_READ;
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_EMIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall    = rst | (state != S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign cmd.capture = (state == S_IDLE) & in_valid & ~rst;
  assign cmd.eval    = (state == S_EVAL);
  assign cmd.load    = (state == S_LOAD);

endmodule

/* sv/srrr_dp.sv */
// srrr_dp.sv
// window state, slot store, configuration registers and output register
// depends on srrr_pkg and srrr_ram
module srrr_dp #(
  parameter int unsigned WINDOW_DEPTH = srrr_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srrr_pkg::srrr_cmd_t           cmd,
  output srrr_pkg::srrr_stat_t          stat,
  input  logic                          cfg_en,
  input  logic                          cfg_index,
  input  logic [srrr_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          action,
  input  logic                          check_ok,
  input  logic [srrr_pkg::SEQ_W-1:0]    seq_number,
  input  logic [srrr_pkg::WORD_W-1:0]   payload_word,
  input  logic [srrr_pkg::LEN_W-1:0]    payload_len,
  input  logic                          final_piece,
  output logic [srrr_pkg::KIND_W-1:0]   kind,
  output logic [srrr_pkg::SEQ_W-1:0]    ack_number,
  output logic [srrr_pkg::WORD_W-1:0]   delivered_word,
  output logic [srrr_pkg::LEN_W-1:0]    delivered_len,
  output logic                          delivered_final,
  output logic                          last_of_run
);
  import srrr_pkg::*;

  localparam int unsigned PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [PW:0]      DEPTH_X   = (PW+1)'(WINDOW_DEPTH);
  localparam logic [PW-1:0]    LAST_SLOT = PW'(WINDOW_DEPTH - 1);
  localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);

  // configuration
  logic [SEQ_W-1:0] total_packets;
  logic [WS_W-1:0]  window_size;

  // window state
  logic [SEQ_W-1:0]        next_expected;
  logic [SEQ_W-1:0]        last_ack;
  logic                    transfer_done;
  logic [WINDOW_DEPTH-1:0] marks;
  logic [PW-1:0]           head;

  // captured input word
  logic              action_r;
  logic              ok_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [WORD_W-1:0] word_r;
  logic [LEN_W-1:0]  len_r;
  logic              final_r;

  logic [SEQ_W-1:0]  win_use;
  logic [SEQ_W-1:0]  off;
  logic              in_win;
  logic [PW:0]       slot_sum;
  logic [PW-1:0]     slot;
  logic              store;
  logic              head_mark_after;
  logic              eval_more;
  logic [PW-1:0]     head_next;
  logic [SEQ_W-1:0]  ne_next;
  logic              mark_at_next;
  logic              load_more;
  logic [SLOT_W-1:0] rd_slot;
  logic [WORD_W-1:0] rd_word;
  logic [LEN_W-1:0]  rd_len;
  logic              rd_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= '0;
      window_size   <= WS_W'(8);
    end else if (cfg_en) begin
      case (cfg_index)
        REG_TOTAL_PACKETS: total_packets <= cfg_data[SEQ_W-1:0];
        REG_WINDOW_SIZE:   window_size   <= cfg_data[WS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action;
      ok_r     <= check_ok;
      seq_r    <= seq_number;
      word_r   <= payload_word;
      len_r    <= payload_len;
      final_r  <= final_piece;
    end
  end

  // window width in use, clamped to one and to the built depth
  always_comb begin
    if (window_size == '0) begin
      win_use = SEQ_W'(1);
    end else if (SEQ_W'(window_size) > DEPTH_SEQ) begin
      win_use = DEPTH_SEQ;
    end else begin
      win_use = SEQ_W'(window_size);
    end
  end

  assign stat.drop = transfer_done | ~ok_r |
                     ((action_r == ACT_FIN) & (last_ack == '0)) |
                     ((action_r == ACT_DATA) & (seq_r == '0));

  assign off      = seq_r - next_expected;
  assign in_win   = (seq_r >= next_expected) & (seq_r <= total_packets) & (off < win_use);
  assign slot_sum = {1'b0, head} + {1'b0, off[PW-1:0]};
  assign slot     = (slot_sum >= DEPTH_X) ? PW'(slot_sum - DEPTH_X) : slot_sum[PW-1:0];
  assign store    = cmd.eval & ~stat.drop & (action_r == ACT_DATA) & in_win & ~marks[slot];

  assign head_mark_after = marks[head] | (store & (slot == head));
  assign eval_more = head_mark_after & (next_expected != '0) & (next_expected <= total_packets);

  assign head_next    = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign ne_next      = next_expected + 1'b1;
  assign mark_at_next = (head_next == head) ? 1'b0 : marks[head_next];
  assign load_more    = mark_at_next & (ne_next != '0) & (ne_next <= total_packets);

  srrr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (PW)
  ) u_slots (
    .clk   (clk),
    .we    (store),
    .waddr (slot),
    .wdata ({word_r, len_r, final_r}),
    .raddr (head),
    .rdata (rd_slot)
  );

  assign {rd_word, rd_len, rd_final} = rd_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= SEQ_W'(1);
      last_ack      <= '0;
      transfer_done <= 1'b0;
      marks         <= '0;
      head          <= '0;
    end else begin
      if (cmd.eval & ~stat.drop) begin
        if (action_r == ACT_FIN) begin
          transfer_done <= 1'b1;
        end else begin
          last_ack <= seq_r;
        end
      end
      if (store) begin
        marks[slot] <= 1'b1;
      end
      if (cmd.load) begin
        marks[head]   <= 1'b0;
        head          <= head_next;
        next_expected <= ne_next;
      end
    end
  end

  // output register, held while the controller waits on the output side
  always_ff @(posedge clk) begin
    if (cmd.eval & ~stat.drop) begin
      ack_number      <= (action_r == ACT_FIN) ? last_ack : seq_r;
      kind            <= (action_r == ACT_FIN) ? KIND_FIN : KIND_ACK;
      delivered_word  <= '0;
      delivered_len   <= '0;
      delivered_final <= 1'b0;
      last_of_run     <= (action_r == ACT_FIN) | ~eval_more;
    end else if (cmd.load) begin
      kind            <= KIND_DLV;
      ack_number      <= '0;
      delivered_word  <= rd_word;
      delivered_len   <= rd_final ? rd_len : FULL_PIECE;
      delivered_final <= rd_final;
      last_of_run     <= ~load_more;
    end
  end

  assign stat.out_last = last_of_run;

endmodule

/* sv/selective_repeat_receive_reorder.sv */
// Selective-repeat receiver with a reorder window. A checked data word (check_ok set, nonzero
// seq_number) is acknowledged at once with kind 0; when it is new, inside the window and not
// beyond total_packets its descriptor, length and final flag go into a window slot. Then every
// consecutive received packet at the window's left edge is released in order as kind 1, with
// delivered_len the packet's own length for the final piece and 12000 otherwise. A checked fin
// word after some data was acknowledged gives one kind 2 word with the last acknowledged number
// and ends the transfer; everything after that is ignored until reset. last_of_run marks the
// final result word of each input. One input word at a time: a dropped word is only evaluated,
// an acknowledgment or fin is then emitted, and each in-order release adds a slot ram read, an
// output load and a hand-off; out_stall holds a result. The window lives in a circular slot ram
// of WINDOW_DEPTH entries with receive marks in flip-flops cleared by reset. Write configuration
// (total_packets at index 0, window_size at index 1) only while idle; the block does not check.
// depends on srrr_pkg, srrr_ctrl, srrr_dp, srrr_ram
module selective_repeat_receive_reorder #(
  parameter int unsigned WINDOW_DEPTH = srrr_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_en,
  input  logic                          cfg_index,
  input  logic [srrr_pkg::CFG_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic                          check_ok,
  input  logic [srrr_pkg::SEQ_W-1:0]    seq_number,
  input  logic [srrr_pkg::WORD_W-1:0]   payload_word,
  input  logic [srrr_pkg::LEN_W-1:0]    payload_len,
  input  logic                          final_piece,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srrr_pkg::KIND_W-1:0]   kind,
  output logic [srrr_pkg::SEQ_W-1:0]    ack_number,
  output logic [srrr_pkg::WORD_W-1:0]   delivered_word,
  output logic [srrr_pkg::LEN_W-1:0]    delivered_len,
  output logic                          delivered_final,
  output logic                          last_of_run
);
  import srrr_pkg::*;

  // commands from the sequencer, status back from the datapath
  srrr_cmd_t  cmd;
  srrr_stat_t stat;

  // sequencer: idle, evaluate, emit, slot read, delivery load
  srrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // window bookkeeping, slot store and the result register
  srrr_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .check_ok        (check_ok),
    .seq_number      (seq_number),
    .payload_word    (payload_word),
    .payload_len     (payload_len),
    .final_piece     (final_piece),
    .kind            (kind),
    .ack_number      (ack_number),
    .delivered_word  (delivered_word),
    .delivered_len   (delivered_len),
    .delivered_final (delivered_final),
    .last_of_run     (last_of_run)
  );

endmodule

/* sv/srrr_chk.sv */
// srrr_chk.sv
// port-level checks of the receive reorder block, bound to the top level
// depends on srrr_pkg and selective_repeat_receive_reorder_defines.svh
`include "selective_repeat_receive_reorder_defines.svh"

module srrr_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [srrr_pkg::KIND_W-1:0]   kind,
  input logic [srrr_pkg::SEQ_W-1:0]    ack_number,
  input logic [srrr_pkg::WORD_W-1:0]   delivered_word,
  input logic                          last_of_run
);
  import srrr_pkg::*;

  // a stalled result word holds
  `SRRR_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(ack_number) && $stable(delivered_word) && $stable(last_of_run), "result word changed while stalled")

  // no new input while a result is pending
  `SRRR_ASSERT(a_one_at_a_time, clk, rst, out_valid |-> in_stall, "input taken while a result is pending")

  // an accepted input blocks the next cycle
  `SRRR_ASSERT(a_accept_blocks, clk, rst, in_valid && !in_stall |=> in_stall, "input taken on back to back cycles")

  // fin acknowledgment always ends its run
  `SRRR_ASSERT(a_fin_last, clk, rst, out_valid && kind == KIND_FIN |-> last_of_run, "fin ack not last of run")

  // nothing offered right after reset
  `SRRR_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result offered after reset")

endmodule

bind selective_repeat_receive_reorder srrr_chk u_srrr_chk (.*);

/* dv/tb_selective_repeat_receive_reorder.sv */
// tb_selective_repeat_receive_reorder.sv
// self-checking bench for the selective-repeat receive reorder block: own window predictor,
// random stimulus and idling on both channels; depends on srrr_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_selective_repeat_receive_reorder;
  import srrr_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;

  // one input word of the receiver
  typedef struct packed {
    logic              action;
    logic              check_ok;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              fin;
  } packet_t;

  // one result word, same field order as the output ports
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  ack;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              fin;
    logic              run_end;
  } result_t;

  // receive window: left edge, last ack and the reorder slots (slot i holds left_edge + i)
  typedef struct packed {
    logic [SEQ_W-1:0]              left_edge;
    logic [SEQ_W-1:0]              last_ack;
    logic [DEPTH-1:0]              marks;
    logic [DEPTH-1:0][WORD_W-1:0]  words;
    logic [DEPTH-1:0][LEN_W-1:0]   lens;
    logic [DEPTH-1:0]              finals;
    logic                          done;
  } rx_window_t;

  // kinds of filler words mixed between the window blocks
  typedef enum int {
    NOISE_UNCHECKED, NOISE_ZERO_SEQ, NOISE_FIN_UNCHECKED,
    NOISE_ANY_SEQ, NOISE_PAST_WINDOW, NOISE_BEHIND_EDGE
  } noise_t;

  logic clk;
  logic rst = 1'b1;

  logic              cfg_en = 1'b0;
  logic              cfg_index = REG_TOTAL_PACKETS;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  packet_t           cur_pkt = '0;
  logic              action;
  logic              check_ok;
  logic [SEQ_W-1:0]  seq_number;
  logic [WORD_W-1:0] payload_word;
  logic [LEN_W-1:0]  payload_len;
  logic              final_piece;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  ack_number;
  logic [WORD_W-1:0] delivered_word;
  logic [LEN_W-1:0]  delivered_len;
  logic              delivered_final;
  logic              last_of_run;
  result_t           out_word;

  // payload ports follow the word held by the driver
  assign action       = cur_pkt.action;
  assign check_ok     = cur_pkt.check_ok;
  assign seq_number   = cur_pkt.seq;
  assign payload_word = cur_pkt.word;
  assign payload_len  = cur_pkt.len;
  assign final_piece  = cur_pkt.fin;
  assign out_word = {kind, ack_number, delivered_word, delivered_len, delivered_final,
                     last_of_run};

  selective_repeat_receive_reorder u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .check_ok        (check_ok),
    .seq_number      (seq_number),
    .payload_word    (payload_word),
    .payload_len     (payload_len),
    .final_piece     (final_piece),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .ack_number      (ack_number),
    .delivered_word  (delivered_word),
    .delivered_len   (delivered_len),
    .delivered_final (delivered_final),
    .last_of_run     (last_of_run)
  );

  // mirror of the configuration registers, changed only while the block is idle
  logic [SEQ_W-1:0] total_cfg = '0;
  logic [WS_W-1:0]  wsize_cfg = WS_W'(8);

  // window_now follows accepted words, window_plan follows generated words so that
  // the generator always knows where the left edge will be
  rx_window_t window_now;
  rx_window_t window_plan;

  packet_t pending_packets[$];
  result_t awaited_results[$];

  bit idle_on = 1'b1;
  bit word_taken = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int accepted_words = 0;
  int phase_words = 0;
  int results_seen = 0;
  int deliveries_seen = 0;
  int run_len = 0;
  int longest_run = 0;
  int errors = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // window register zero counts as one, anything above the built depth as the depth
  function automatic int window_used();
    if (wsize_cfg == '0) return 1;
    if (int'(wsize_cfg) > DEPTH) return DEPTH;
    return int'(wsize_cfg);
  endfunction

  // response of the receiver to one word; updates the window copy given and, when asked,
  // queues the results in the order the block must send them
  function automatic int receiver_response(inout rx_window_t st, input packet_t p,
                                           input bit record);
    result_t run [0:DEPTH];
    int n;
    int off;
    int i;
    n = 0;
    // everything is dropped after the transfer ends, and unchecked words always
    if (st.done || !p.check_ok) return 0;
    if (p.action == ACT_FIN) begin
      // a fin only counts once some data was acknowledged
      if (st.last_ack == '0) return 0;
      run[0] = '0;
      run[0].kind = KIND_FIN;
      run[0].ack = st.last_ack;
      n = 1;
      st.done = 1'b1;
    end else begin
      if (p.seq == '0) return 0;
      st.last_ack = p.seq;
      run[0] = '0;
      run[0].kind = KIND_ACK;
      run[0].ack = p.seq;
      n = 1;
      // store only new words inside the window and not beyond the total
      if (p.seq >= st.left_edge && p.seq <= total_cfg) begin
        off = int'(p.seq) - int'(st.left_edge);
        if (off < window_used() && !st.marks[off]) begin
          st.marks[off] = 1'b1;
          st.words[off] = p.word;
          st.lens[off] = p.len;
          st.finals[off] = p.fin;
        end
      end
      // release from the left edge; stops past the total and once the edge wraps to zero
      while (st.marks[0] && st.left_edge != '0 && st.left_edge <= total_cfg) begin
        run[n] = '0;
        run[n].kind = KIND_DLV;
        run[n].word = st.words[0];
        run[n].len = st.finals[0] ? st.lens[0] : FULL_PIECE;
        run[n].fin = st.finals[0];
        n++;
        st.marks = st.marks >> 1;
        st.words = {{WORD_W{1'b0}}, st.words[DEPTH-1:1]};
        st.lens = {{LEN_W{1'b0}}, st.lens[DEPTH-1:1]};
        st.finals = st.finals >> 1;
        st.left_edge = st.left_edge + SEQ_W'(1);
      end
    end
    if (record) begin
      run[n-1].run_end = 1'b1;
      for (i = 0; i < n; i++) awaited_results.push_back(run[i]);
    end
    return n;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind=%0d ack=%0d word=%h len=%0d final=%0b last=%0b",
                     r.kind, r.ack, r.word, r.len, r.fin, r.run_end);
  endfunction

  // checked data word with random payload
  function automatic packet_t data_packet(logic [SEQ_W-1:0] seq);
    packet_t p;
    p.action = ACT_DATA;
    p.check_ok = 1'b1;
    p.seq = seq;
    p.word = {$urandom, $urandom};
    p.len = LEN_W'($urandom_range(0, 12000));
    p.fin = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic void enqueue_packet(packet_t p);
    if (receiver_response(window_plan, p, 1'b0) != 0) phase_words++;
    pending_packets.push_back(p);
  endfunction

  function automatic void queue_noise();
    packet_t p;
    noise_t pick;
    pick = noise_t'($urandom_range(0, 5));
    p = data_packet(SEQ_W'($urandom_range(0, 65535)));
    case (pick)
      NOISE_UNCHECKED: p.check_ok = 1'b0;
      NOISE_ZERO_SEQ: p.seq = '0;
      NOISE_FIN_UNCHECKED: begin
        p.action = ACT_FIN;
        p.check_ok = 1'b0;
      end
      NOISE_ANY_SEQ: ;
      NOISE_PAST_WINDOW:
        p.seq = window_plan.left_edge + SEQ_W'(window_used()) + SEQ_W'($urandom_range(0, 3));
      default: p.seq = window_plan.left_edge - SEQ_W'($urandom_range(1, 3));
    endcase
    enqueue_packet(p);
  endfunction

  // one window's worth of sequences from the planned left edge, shuffled; with breaks on,
  // a sequence may be held back or repeated
  function automatic void queue_window_block(bit breaks);
    logic [SEQ_W-1:0] seqs [0:DEPTH-1];
    logic [SEQ_W-1:0] tmp;
    int n;
    int held;
    int j;
    int k;
    if (window_plan.left_edge == '0 || window_plan.left_edge > total_cfg) begin
      queue_noise();
      return;
    end
    n = int'(total_cfg) - int'(window_plan.left_edge) + 1;
    if (n > window_used()) n = window_used();
    for (j = 0; j < n; j++) seqs[j] = window_plan.left_edge + SEQ_W'(j);
    for (j = n - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = seqs[j];
      seqs[j] = seqs[k];
      seqs[k] = tmp;
    end
    held = (breaks && $urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : -1;
    for (j = 0; j < n; j++)
      if (j != held) enqueue_packet(data_packet(seqs[j]));
    if (breaks && $urandom_range(0, 9) == 0)
      enqueue_packet(data_packet(seqs[$urandom_range(0, n - 1)]));
  endfunction

  // wait until every word is in and every result is out, then let a dropped word finish
  task automatic settle();
    while (pending_packets.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_en <= 1'b0;
    if (idx == REG_TOTAL_PACKETS) total_cfg = data;
    else wsize_cfg = data[WS_W-1:0];
  endtask

  // sender: record accepted words and predict what they cause
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        void'(receiver_response(window_now, cur_pkt, 1'b1));
        accepted_words++;
      end
    end
  end

  // sender: present the next word at the falling edge, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_packets.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (pending_packets.size() != 0) begin
        cur_pkt <= pending_packets.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold so the block backs up its input
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!long_hold_done && accepted_words >= 60) begin
        long_hold_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // receiver: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_word.kind == KIND_DLV) deliveries_seen++;
      run_len++;
      if (out_word.run_end) begin
        if (run_len > longest_run) longest_run = run_len;
        run_len = 0;
      end
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: result with none expected, got %s", $time, show(out_word));
      end else begin
        want = awaited_results.pop_front();
        if (out_word !== want) begin
          errors++;
          if (errors <= 50)
            $display("%0t: result mismatch, expected %s, got %s", $time, show(want),
                     show(out_word));
        end
      end
    end
  end

  initial begin : stimulus
    packet_t p;
    window_now = '0;
    window_now.left_edge = SEQ_W'(1);
    window_plan = window_now;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset settings, total of zero: ignored words and an ack beyond the total
    p = data_packet('0);
    p.action = ACT_FIN;                  // fin before any data ack
    enqueue_packet(p);
    p = data_packet(SEQ_W'(1));
    p.check_ok = 1'b0;                   // unchecked data
    enqueue_packet(p);
    enqueue_packet(data_packet('0));     // zero sequence
    p = data_packet(SEQ_W'(7));
    p.action = ACT_FIN;
    p.check_ok = 1'b0;                   // unchecked fin
    enqueue_packet(p);
    p = data_packet(SEQ_W'(65535));
    p.word = '1;
    p.len = LEN_W'(12000);
    p.fin = 1'b1;
    enqueue_packet(p);
    settle();

    // window of one: out of window, in order, behind the edge
    cfg_write(REG_TOTAL_PACKETS, CFG_W'(12));
    cfg_write(REG_WINDOW_SIZE, CFG_W'(1));
    enqueue_packet(data_packet(SEQ_W'(2)));
    p = data_packet(SEQ_W'(1));
    p.word = '0;
    p.len = '0;
    p.fin = 1'b0;
    enqueue_packet(p);
    enqueue_packet(data_packet(SEQ_W'(1)));
    p = data_packet(SEQ_W'(2));
    p.len = '0;
    p.fin = 1'b1;
    enqueue_packet(p);
    settle();

    // window register zero behaves as one
    cfg_write(REG_WINDOW_SIZE, CFG_W'(0));
    enqueue_packet(data_packet(SEQ_W'(4)));
    enqueue_packet(data_packet(SEQ_W'(3)));
    settle();

    // window register fifteen behaves as the full depth: fill it backwards, repeat one
    // sequence, then the left edge releases the whole window in one run
    cfg_write(REG_WINDOW_SIZE, CFG_W'(15));
    for (int s = 11; s >= 5; s--) enqueue_packet(data_packet(SEQ_W'(s)));
    enqueue_packet(data_packet(SEQ_W'(11)));
    enqueue_packet(data_packet(SEQ_W'(12)));
    enqueue_packet(data_packet(SEQ_W'(4)));
    p = data_packet(SEQ_W'(12));
    p.len = LEN_W'(12000);
    p.fin = 1'b1;
    enqueue_packet(p);
    enqueue_packet(data_packet(SEQ_W'(13)));   // edge already past the total

    // random phases: mostly shuffled window blocks, some filler and broken blocks
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      cfg_write(REG_WINDOW_SIZE, CFG_W'($urandom_range(0, 15)));
      cfg_write(REG_TOTAL_PACKETS, CFG_W'(window_plan.left_edge) + CFG_W'($urandom_range(4, 40)));
      phase_words = 0;
      while (phase_words < 24) begin
        if ($urandom_range(0, 4) == 0) queue_noise();
        else queue_window_block(1'b1);
      end
    end

    // last part, no idling: a few full windows under the largest total
    settle();
    idle_on = 1'b0;
    cfg_write(REG_TOTAL_PACKETS, CFG_W'(65535));
    cfg_write(REG_WINDOW_SIZE, CFG_W'(8));
    for (int b = 0; b < 3; b++) queue_window_block(1'b0);
    enqueue_packet(data_packet(SEQ_W'(1)));
    enqueue_packet(data_packet(SEQ_W'(65535)));
    // fin ends the transfer; everything after it is dropped
    p = data_packet(SEQ_W'(3));
    p.action = ACT_FIN;
    enqueue_packet(p);
    enqueue_packet(data_packet(SEQ_W'(2)));
    enqueue_packet(p);
    settle();

    $display("covered %0d input words, %0d results checked, %0d of them in-order deliveries",
             accepted_words, results_seen, deliveries_seen);
    $display("windows of zero to fifteen, totals up to 65535, longest run %0d results",
             longest_run);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin : watchdog
    #6_000_000;
    $display("timeout with %0d results still awaited", awaited_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
